@@ rtl/lru_pkg.sv @@
// Shared types and constants for the LRU page replacement unit.
package lru_pkg;

  localparam int CFG_W     = 4;
  localparam int OUT_IDX_W = 3;
  localparam int FAULT_W   = 32;

  localparam logic [CFG_W-1:0] FRAME_CNT_RST = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lru_state_e;

endpackage

@@ rtl/lru_req_if.sv @@
// Request channel: one page reference per request.
interface lru_req_if #(
  parameter int PAGE_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;
  logic                 last_reference;

  modport source (output valid, page, last_reference, input ready);
  modport sink   (input valid, page, last_reference, output ready);
endinterface

@@ rtl/lru_rsp_if.sv @@
// Result channel: outcome of one page reference.
interface lru_rsp_if #(
  parameter int PAGE_BITS = 16
) ();
  import lru_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [OUT_IDX_W-1:0] frame_index;
  logic                 evicted_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [FAULT_W-1:0]   fault_count;
  logic                 string_done;

  modport source (output valid, hit, frame_index, evicted_valid, evicted_page, fault_count,
                  string_done, input ready);
  modport sink   (input valid, hit, frame_index, evicted_valid, evicted_page, fault_count,
                  string_done, output ready);
endinterface

@@ rtl/lru_cell.sv @@
// One frame cell: page, valid and rank, with its stage of the search wave.
module lru_cell #(
  parameter int  IDX       = 0,
  parameter int  IDX_W     = 3,
  parameter int  RANK_W    = 3,
  parameter int  PAGE_BITS = 16,
  parameter int  CNT_W     = 4,
  parameter type carry_t   = logic,
  parameter type upd_t     = logic
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CNT_W-1:0]     n_use_i,
  input  logic [PAGE_BITS-1:0] key_i,
  input  carry_t               carry_i,
  input  upd_t                 upd_i,
  output carry_t               carry_o
);

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic [RANK_W-1:0]    rank_q;
  carry_t               carry_q;
  carry_t               carry_d;
  logic                 in_range;
  logic                 is_target;

  assign in_range  = CNT_W'(IDX) < n_use_i;
  assign is_target = upd_i.target == IDX_W'(IDX);

  always_comb begin
    carry_d = carry_i;
    if (carry_i.valid && in_range) begin
      if (valid_q && (page_q == key_i) && !carry_i.hit) begin
        carry_d.hit      = 1'b1;
        carry_d.hit_idx  = IDX_W'(IDX);
        carry_d.hit_rank = rank_q;
      end
      if (!valid_q && !carry_i.free) begin
        carry_d.free     = 1'b1;
        carry_d.free_idx = IDX_W'(IDX);
      end
      if (valid_q && (!carry_i.vic || (rank_q > carry_i.vic_rank))) begin
        carry_d.vic      = 1'b1;
        carry_d.vic_idx  = IDX_W'(IDX);
        carry_d.vic_rank = rank_q;
        carry_d.vic_page = page_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else if (carry_i.valid) begin
      carry_q <= carry_d;
    end else begin
      carry_q.valid <= 1'b0;
    end
  end

  assign carry_o = carry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (upd_i.en) begin
      if (upd_i.clear) begin
        valid_q <= 1'b0;
        rank_q  <= '0;
      end else if (is_target) begin
        valid_q <= 1'b1;
        rank_q  <= '0;
      end else if (valid_q && (!upd_i.keep_order || (rank_q < upd_i.old_rank))) begin
        rank_q <= rank_q + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en && upd_i.wr_page && is_target) begin
      page_q <= upd_i.page;
    end
  end

endmodule

@@ rtl/lru_page_replacement_unit.sv @@
// LRU page replacement unit: request control, result register and the row of frame cells.
//
//  channel   dir  port         contents
//  request   in   req_i        page, last_reference
//  result    out  rsp_o        hit, frame_index, evicted_valid, evicted_page,
//                              fault_count, string_done
//  config    in   cfg_we_i     frame count on cfg_wdata_i
//
// A request is taken only in the idle state, so one is in flight at a time. It passes a launch
// step, then the search wave steps through the row of FRAMES cells, one register per cell,
// then a hand-off step and an update step; the update waits while a result is stalled.
// Reset empties every frame, clears ranks and the fault count, and sets the frame count to 8.
// A stalled result holds in the output register; the next request is still taken, and
// its update waits only until that result is gone.
module lru_page_replacement_unit #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lru_pkg::CFG_W-1:0] cfg_wdata_i,
  lru_req_if.sink                   req_i,
  lru_rsp_if.source                 rsp_o
);
  import lru_pkg::*;

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [RANK_W-1:0]    hit_rank;
    logic                 free;
    logic [IDX_W-1:0]     free_idx;
    logic                 vic;
    logic [IDX_W-1:0]     vic_idx;
    logic [RANK_W-1:0]    vic_rank;
    logic [PAGE_BITS-1:0] vic_page;
  } carry_t;

  typedef struct packed {
    logic                 en;
    logic                 clear;
    logic [IDX_W-1:0]     target;
    logic                 keep_order;
    logic [RANK_W-1:0]    old_rank;
    logic                 wr_page;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

  lru_state_e           state_q, state_d;
  logic [CFG_W-1:0]     frame_cnt_q;
  logic [CNT_W-1:0]     n_use;
  logic [PAGE_BITS-1:0] page_q;
  logic                 last_q;
  logic                 start_q, start_d;
  logic [FAULT_W-1:0]   faults_q;
  logic [FAULT_W-1:0]   fault_next;

  logic                 out_valid_q;
  logic                 out_hit_q;
  logic [OUT_IDX_W-1:0] out_frame_q;
  logic                 out_ev_valid_q;
  logic [PAGE_BITS-1:0] out_ev_page_q;
  logic [FAULT_W-1:0]   out_fault_q;
  logic                 out_done_q;

  carry_t               carry_head;
  carry_t               carry_w [FRAMES];
  carry_t               carry_last;
  logic [FRAMES-1:0]    carry_vld;
  upd_t                 upd;
  logic                 req_fire;
  logic                 do_upd;
  logic                 is_fill;
  logic                 is_repl;
  logic [IDX_W-1:0]     target;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cnt_q <= FRAME_CNT_RST;
    end else if (cfg_we_i) begin
      frame_cnt_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (frame_cnt_q == '0) begin
      n_use = CNT_W'(1);
    end else if (int'(frame_cnt_q) > FRAMES) begin
      n_use = CNT_W'(FRAMES);
    end else begin
      n_use = CNT_W'(frame_cnt_q);
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign do_upd      = (state_q == ST_UPDATE) && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
    end
  end

  always_comb begin
    state_d = state_q;
    start_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_SCAN;
          start_d = 1'b1;
        end
      end
      ST_SCAN: begin
        if (carry_last.valid) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (do_upd) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      page_q <= req_i.page;
      last_q <= req_i.last_reference;
    end
  end

  // search wave enters at cell 0
  always_comb begin
    carry_head       = '0;
    carry_head.valid = start_q;
  end

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    if (k == 0) begin : g_head
      lru_cell #(
        .IDX(k), .IDX_W(IDX_W), .RANK_W(RANK_W), .PAGE_BITS(PAGE_BITS), .CNT_W(CNT_W),
        .carry_t(carry_t), .upd_t(upd_t)
      ) u_cell (
        .clk_i(clk_i), .rst_ni(rst_ni), .n_use_i(n_use), .key_i(page_q),
        .carry_i(carry_head), .upd_i(upd), .carry_o(carry_w[k])
      );
    end else begin : g_body
      lru_cell #(
        .IDX(k), .IDX_W(IDX_W), .RANK_W(RANK_W), .PAGE_BITS(PAGE_BITS), .CNT_W(CNT_W),
        .carry_t(carry_t), .upd_t(upd_t)
      ) u_cell (
        .clk_i(clk_i), .rst_ni(rst_ni), .n_use_i(n_use), .key_i(page_q),
        .carry_i(carry_w[k-1]), .upd_i(upd), .carry_o(carry_w[k])
      );
    end
    assign carry_vld[k] = carry_w[k].valid;
  end

  assign carry_last = carry_w[FRAMES-1];

  assign is_fill = !carry_last.hit && carry_last.free;
  assign is_repl = !carry_last.hit && !carry_last.free;

  always_comb begin
    if (carry_last.hit) begin
      target = carry_last.hit_idx;
    end else if (carry_last.free) begin
      target = carry_last.free_idx;
    end else begin
      target = carry_last.vic_idx;
    end
  end

  assign fault_next = (!carry_last.hit && (faults_q != {FAULT_W{1'b1}})) ?
                      faults_q + FAULT_W'(1) : faults_q;

  always_comb begin
    upd            = '0;
    upd.en         = do_upd;
    upd.clear      = last_q;
    upd.target     = target;
    upd.keep_order = carry_last.hit || is_repl;
    upd.old_rank   = carry_last.hit ? carry_last.hit_rank : carry_last.vic_rank;
    upd.wr_page    = is_fill || is_repl;
    upd.page       = page_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      faults_q <= '0;
    end else if (do_upd) begin
      faults_q <= last_q ? '0 : fault_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_upd) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_upd) begin
      out_hit_q      <= carry_last.hit;
      out_frame_q    <= OUT_IDX_W'(target);
      out_ev_valid_q <= is_repl;
      out_ev_page_q  <= is_repl ? carry_last.vic_page : '0;
      out_fault_q    <= fault_next;
      out_done_q     <= last_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.frame_index   = out_frame_q;
  assign rsp_o.evicted_valid = out_ev_valid_q;
  assign rsp_o.evicted_page  = out_ev_page_q;
  assign rsp_o.fault_count   = out_fault_q;
  assign rsp_o.string_done   = out_done_q;

  a_one_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(carry_vld))
    else $error("more than one search wave in the cell row");

  a_rsp_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPDATE))
    else $error("result raised outside the update step");

  a_req_starts_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> start_q && (state_q == ST_SCAN))
    else $error("accepted request did not launch a search");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_hit_q |-> !out_ev_valid_q)
    else $error("eviction reported on a hit");

endmodule

@@ dv/lru_page_replacement_unit_test.sv @@
// Testbench for the LRU page replacement unit: directed table, random reference strings, scoreboard.
`timescale 1ns / 1ps

module lru_page_replacement_unit_test;
  import lru_pkg::*;

  localparam int FRAMES       = 8;
  localparam int PAGE_BITS    = 16;
  localparam int LATENCY      = FRAMES + 3;
  localparam int RANDOM_ITEMS = 1250;
  localparam int LONG_HOLD    = 300;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic                 hit;
    logic [OUT_IDX_W-1:0] frame_index;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [FAULT_W-1:0]   fault_count;
    logic                 string_done;
  } outcome_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_W-1:0]     cfg_value;
    logic [PAGE_BITS-1:0] page;
    logic                 last_ref;
    logic                 typed;
    outcome_t             exp;
  } dir_row_t;

  localparam outcome_t NO_EXP = '0;
  localparam int DIRECTED_ROWS = 23;
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, 4'd0,  16'h0000, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1, 1'b0}},
    '{1'b0, 4'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd2, 1'b0}},
    '{1'b0, 4'd0,  16'h0000, 1'b0, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd2, 1'b0}},
    '{1'b0, 4'd0,  16'h0001, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h0002, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h0003, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h0004, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h0005, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h0006, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h0007, 1'b0, 1'b0, NO_EXP},
    '{1'b1, 4'd0,  16'h0000, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h5555, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h5555, 1'b0, 1'b0, NO_EXP},
    '{1'b1, 4'd15, 16'h0000, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h0007, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'hAAAA, 1'b0, 1'b0, NO_EXP},
    '{1'b1, 4'd3,  16'h0000, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h0003, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h8000, 1'b1, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h1234, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1, 1'b0}},
    '{1'b0, 4'd0,  16'h1234, 1'b1, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd1, 1'b1}},
    '{1'b1, 4'd8,  16'h0000, 1'b0, 1'b0, NO_EXP},
    '{1'b0, 4'd0,  16'h00FF, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1, 1'b1}}
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lru_req_if #(.PAGE_BITS(PAGE_BITS)) req ();
  lru_rsp_if #(.PAGE_BITS(PAGE_BITS)) rsp ();

  lru_page_replacement_unit #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted frame store
  logic [PAGE_BITS-1:0] frame_pages [FRAMES];
  logic                 frame_held  [FRAMES];
  int unsigned          frame_rank  [FRAMES];
  logic [FAULT_W-1:0]   fault_total;
  logic [CFG_W-1:0]     frame_cfg;

  outcome_t pending_outcomes [$];
  int       errors = 0;
  int       cycles = 0;
  logic     tx_calm = 1'b0;
  logic     rx_calm = 1'b0;
  logic     long_hold_req = 1'b0;

  function automatic int unsigned frames_in_use();
    if (frame_cfg == '0) return 1;
    if (32'(frame_cfg) > FRAMES) return FRAMES;
    return 32'(frame_cfg);
  endfunction

  function automatic void make_most_recent(input int unsigned f, input logic was_held);
    int unsigned old_rank;
    old_rank = frame_rank[f];
    for (int i = 0; i < FRAMES; i++) begin
      if (i != f && frame_held[i] && (!was_held || frame_rank[i] < old_rank)) begin
        frame_rank[i]++;
      end
    end
    frame_rank[f] = 0;
    frame_held[f] = 1'b1;
  endfunction

  function automatic void clear_frame_store();
    for (int i = 0; i < FRAMES; i++) begin
      frame_pages[i] = '0;
      frame_held[i]  = 1'b0;
      frame_rank[i]  = 0;
    end
    fault_total = '0;
  endfunction

  function automatic outcome_t predict_reference(input logic [PAGE_BITS-1:0] pg,
                                                 input logic last_ref);
    outcome_t    res;
    int unsigned n;
    int unsigned tgt;
    logic        found;
    logic        got_free;
    res      = '0;
    n        = frames_in_use();
    tgt      = 0;
    found    = 1'b0;
    got_free = 1'b0;
    for (int f = 0; f < n; f++) begin
      if (!found && frame_held[f] && frame_pages[f] == pg) begin
        tgt   = f;
        found = 1'b1;
      end
    end
    if (found) begin
      make_most_recent(tgt, 1'b1);
    end else begin
      if (fault_total != '1) fault_total++;
      for (int f = 0; f < n; f++) begin
        if (!got_free && !frame_held[f]) begin
          tgt      = f;
          got_free = 1'b1;
        end
      end
      if (got_free) begin
        frame_pages[tgt] = pg;
        make_most_recent(tgt, 1'b0);
      end else begin
        tgt = 0;
        for (int f = 1; f < n; f++) begin
          if (frame_rank[f] > frame_rank[tgt]) tgt = f;
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = frame_pages[tgt];
        frame_pages[tgt]  = pg;
        make_most_recent(tgt, 1'b1);
      end
    end
    res.hit         = found;
    res.frame_index = tgt[OUT_IDX_W-1:0];
    res.fault_count = fault_total;
    res.string_done = last_ref;
    if (last_ref) clear_frame_store();
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp,
                                      input logic [31:0] got);
    if (got !== exp) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, got);
      errors++;
    end
  endfunction

  task automatic send_reference(input logic [PAGE_BITS-1:0] pg, input logic last_ref,
                                input logic typed, input outcome_t typed_exp);
    int       gap;
    outcome_t predicted;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid          = 1'b1;
    req.page           = pg;
    req.last_reference = last_ref;
    do @(posedge clk); while (!req.ready);
    predicted = predict_reference(pg, last_ref);
    pending_outcomes.push_back(typed ? typed_exp : predicted);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    req.valid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic write_frame_count(input logic [CFG_W-1:0] value);
    wait_for_results();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    frame_cfg = value;
  endtask

  // one reference string with locality over a small working set, plus noise
  task automatic run_string(output int sent);
    logic [PAGE_BITS-1:0] working_set [12];
    int                   ws;
    int                   len;
    logic                 ends_string;
    logic [PAGE_BITS-1:0] pg;
    logic                 last_ref;
    ws = $urandom_range(1, (frames_in_use() + 3 > 12) ? 12 : frames_in_use() + 3);
    for (int i = 0; i < 12; i++) working_set[i] = PAGE_BITS'($urandom_range(0, 65535));
    len         = $urandom_range(1, 40);
    ends_string = ($urandom_range(0, 4) != 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 6) == 0) pg = PAGE_BITS'($urandom_range(0, 65535));
      else pg = working_set[$urandom_range(0, ws - 1)];
      last_ref = (i == len - 1 && ends_string) || ($urandom_range(0, 49) == 0);
      send_reference(pg, last_ref, 1'b0, NO_EXP);
    end
    sent = len;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side
  initial begin
    int       stall;
    outcome_t exp;
    rsp.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall         = LONG_HOLD;
      end
      if (stall > 0) begin
        rsp.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready = 1'b1;
      do @(posedge clk); while (!rsp.valid);
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time,
                 {rsp.hit, rsp.frame_index, rsp.evicted_valid, rsp.evicted_page,
                  rsp.fault_count, rsp.string_done});
        errors++;
      end else begin
        exp = pending_outcomes.pop_front();
        check_field("hit", 32'(exp.hit), 32'(rsp.hit));
        check_field("frame_index", 32'(exp.frame_index), 32'(rsp.frame_index));
        check_field("evicted_valid", 32'(exp.evicted_valid), 32'(rsp.evicted_valid));
        check_field("evicted_page", 32'(exp.evicted_page), 32'(rsp.evicted_page));
        check_field("fault_count", exp.fault_count, rsp.fault_count);
        check_field("string_done", 32'(exp.string_done), 32'(rsp.string_done));
      end
    end
  end

  // request side
  initial begin
    int               random_items;
    int               sent;
    int               phase;
    int               pick;
    logic [CFG_W-1:0] cfg_val;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    req.valid          = 1'b0;
    req.page           = '0;
    req.last_reference = 1'b0;
    frame_cfg          = FRAME_CNT_RST;
    clear_frame_store();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].is_cfg) begin
        write_frame_count(DIRECTED[r].cfg_value);
      end else begin
        send_reference(DIRECTED[r].page, DIRECTED[r].last_ref, DIRECTED[r].typed,
                       DIRECTED[r].exp);
      end
    end

    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          cfg_val = '0;
        end
        1: begin
          cfg_val = CFG_W'($urandom_range(FRAMES + 1, 15));
        end
        2: begin
          cfg_val = CFG_W'(FRAMES);
        end
        3: begin
          cfg_val = CFG_W'(1);
        end
        default: begin
          cfg_val = CFG_W'($urandom_range(1, FRAMES));
        end
      endcase
      write_frame_count(cfg_val);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        tx_calm       = 1'b1;
        long_hold_req = 1'b1;
      end
      repeat ($urandom_range(2, 5)) begin
        run_string(sent);
        random_items += sent;
      end
      phase++;
    end

    wait_for_results();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lru_pkg.sv
rtl/lru_req_if.sv
rtl/lru_rsp_if.sv
rtl/lru_cell.sv
rtl/lru_page_replacement_unit.sv
dv/lru_page_replacement_unit_test.sv
